>>> src/chs_pkg.sv
`timescale 1ns / 1ps
package chs_pkg;

	localparam int MAX_SHIFT = 32;
	localparam int MAX_WIDTH = 4096;

	localparam int SAMPLE_W = 8;
	localparam int PLANE_W  = 2;
	localparam int LW_W     = $clog2(MAX_WIDTH + 1);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int CW_W     = $clog2(MAX_WIDTH / 2 + 1);
	localparam int SHIFT_W  = 7;
	localparam int MAG_W    = $clog2(MAX_SHIFT + 1);
	localparam int TAP_W    = $clog2(MAX_SHIFT);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LW_W;

	localparam logic [PLANE_W-1:0] PLANE_Y    = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_U    = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_V    = 2'd2;
	localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_LUMA_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_U_SHIFT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_V_SHIFT    = 2'd2;

	localparam logic [LW_W-1:0]     LUMA_WIDTH_RESET = LW_W'(640);
	localparam logic [SAMPLE_W-1:0] BLANK_CHROMA     = 8'd128;
	localparam logic [SAMPLE_W-1:0] BLANK_LUMA       = 8'd0;

	// Results caused by one input item: an optional primary sample, then
	// a run of blank chroma samples at the end of a left-shifted row.
	typedef struct packed {
		logic [PLANE_W-1:0]  plane;
		logic [SAMPLE_W-1:0] value;
		logic                prim;
		logic [MAG_W-1:0]    flush;
	} chs_rec_t;

endpackage

>>> src/chs_if.sv
`timescale 1ns / 1ps
interface chs_in_if;
	import chs_pkg::*;
	logic                valid;
	logic                ready;
	logic [PLANE_W-1:0]  plane;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output plane, output sample, input ready);
	modport sink   (input valid, input plane, input sample, output ready);
endinterface

interface chs_out_if;
	import chs_pkg::*;
	logic                valid;
	logic                ready;
	logic [PLANE_W-1:0]  out_plane;
	logic [SAMPLE_W-1:0] out_sample;
	logic                last_in_run;

	modport source (output valid, output out_plane, output out_sample, output last_in_run,
		input ready);
	modport sink   (input valid, input out_plane, input out_sample, input last_in_run,
		output ready);
endinterface

>>> src/chs_cell.sv
`timescale 1ns / 1ps
module chs_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [chs_pkg::SAMPLE_W-1:0]  d,
	output logic [chs_pkg::SAMPLE_W-1:0]  q
);
	import chs_pkg::*;

	logic [SAMPLE_W-1:0] smp_q;

	// Take the neighbor's sample on every chroma item.
	always_ff @(posedge clk) begin
		if (en) begin
			smp_q <= d;
		end
	end

	assign q = smp_q;
endmodule

>>> src/chs_emit.sv
`timescale 1ns / 1ps
module chs_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  chs_pkg::chs_rec_t rec,
	output logic              full,
	chs_out_if.source         out_ch
);
	import chs_pkg::*;

	chs_rec_t head_q, tail_q, head_d, tail_d;
	logic     head_v_q, tail_v_q, head_v_d, tail_v_d;
	logic     fire, last;

	assign last = head_q.prim ? (head_q.flush == '0) : (head_q.flush == MAG_W'(1));
	assign fire = head_v_q && out_ch.ready;

	assign out_ch.valid       = head_v_q;
	assign out_ch.out_plane   = head_q.plane;
	assign out_ch.out_sample  = head_q.prim ? head_q.value : BLANK_CHROMA;
	assign out_ch.last_in_run = last;
	assign full = tail_v_q;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		head_v_d = head_v_q;
		tail_v_d = tail_v_q;
		if (fire) begin
			if (last) begin
				head_d   = tail_q;
				head_v_d = tail_v_q;
				tail_v_d = 1'b0;
			end else if (head_q.prim) begin
				head_d.prim = 1'b0;
			end else begin
				head_d.flush = head_q.flush - MAG_W'(1);
			end
		end
		if (push) begin
			if (!head_v_d) begin
				head_d   = rec;
				head_v_d = 1'b1;
			end else begin
				tail_d   = rec;
				tail_v_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else begin
			head_v_q <= head_v_d;
			tail_v_q <= tail_v_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
		tail_q <= tail_d;
	end
endmodule

>>> src/chroma_horizontal_shift.sv
`timescale 1ns / 1ps
// Chroma horizontal shift for planar 4:2:0 video. The block takes one sample per cycle
// while in_ch.ready is high and registers its results in a two-item output buffer; the
// last chroma sample of a row under a negative shift ends with a burst of up to 33
// results, one per cycle while the output is ready, and the next item waits once that
// buffer is full. Input is held off after reset and after every register write. Positive
// shifts read the sample from a chain of 32 cells that moves by one on every chroma item,
// so a shift of p takes the sample p items back.
module chroma_horizontal_shift (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [chs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [chs_pkg::CFG_DATA_W-1:0]   cfg_data,
	chs_in_if.sink                           in_ch,
	chs_out_if.source                        out_ch
);
	import chs_pkg::*;

	// Programmed registers
	logic [LW_W-1:0]    luma_width_q;
	logic [SHIFT_W-1:0] u_shift_q, v_shift_q;
	logic               cfg_hold_q;

	// Settled configuration
	logic [LW_W-1:0]  lw_q;
	logic [CW_W-1:0]  cw_q;
	logic [MAG_W-1:0] mag_u_q, mag_v_q;
	logic             neg_u_q, neg_v_q, pos_u_q, pos_v_q;
	logic [MAG_W-1:0] lo_c_q;
	logic [CW_W-1:0]  hi_c_q;

	logic [LW_W-1:0]    w_m, lw_d;
	logic [CW_W-1:0]    cw_d, lim_full;
	logic [MAG_W-1:0]   lim;
	logic [SHIFT_W-1:0] raw_u, raw_v;
	logic [MAG_W-1:0]   mag_u_d, mag_v_d, lo_u, lo_v;
	logic [CW_W-1:0]    hi_u, hi_v;

	// Row state
	logic [COL_W-1:0]   col_q;
	logic [PLANE_W-1:0] cur_plane_q;

	logic [SAMPLE_W-1:0] cell_q [MAX_SHIFT];
	logic                shift_en;

	logic               in_fire, act, newrow, is_luma;
	logic [LW_W-1:0]    rw, c_inc;
	logic [COL_W-1:0]   c;
	logic [MAG_W-1:0]   mag;
	logic               neg, pos;
	logic [TAP_W-1:0]   tap_idx;
	logic [SAMPLE_W-1:0] tap;
	logic [COL_W-1:0]   oc;
	logic               blank_c, blank_l;
	chs_rec_t           rec;
	logic               push, full;

	// Hold input after reset, and after every register write, until the settled registers load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_width_q <= LUMA_WIDTH_RESET;
			u_shift_q    <= '0;
			v_shift_q    <= '0;
			cfg_hold_q   <= 1'b1;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LUMA_WIDTH: luma_width_q <= cfg_data;
					CFG_U_SHIFT:    u_shift_q    <= cfg_data[SHIFT_W-1:0];
					CFG_V_SHIFT:    v_shift_q    <= cfg_data[SHIFT_W-1:0];
					default:        ;
				endcase
			end
		end
	end

	// Clamp width, saturate shifts and fold both shifts into one blank band.
	always_comb begin
		w_m = luma_width_q & ~LW_W'(1);
		if (w_m < LW_W'(2)) begin
			lw_d = LW_W'(2);
		end else if (w_m > LW_W'(MAX_WIDTH)) begin
			lw_d = LW_W'(MAX_WIDTH);
		end else begin
			lw_d = w_m;
		end
		cw_d     = lw_d[LW_W-1:1];
		lim_full = cw_d - CW_W'(1);
		lim      = (lim_full > CW_W'(MAX_SHIFT)) ? MAG_W'(MAX_SHIFT) : lim_full[MAG_W-1:0];
		raw_u    = u_shift_q[SHIFT_W-1] ? -u_shift_q : u_shift_q;
		raw_v    = v_shift_q[SHIFT_W-1] ? -v_shift_q : v_shift_q;
		mag_u_d  = (raw_u > SHIFT_W'(lim)) ? lim : raw_u[MAG_W-1:0];
		mag_v_d  = (raw_v > SHIFT_W'(lim)) ? lim : raw_v[MAG_W-1:0];
		lo_u     = u_shift_q[SHIFT_W-1] ? '0 : mag_u_d;
		lo_v     = v_shift_q[SHIFT_W-1] ? '0 : mag_v_d;
		hi_u     = u_shift_q[SHIFT_W-1] ? cw_d - CW_W'(mag_u_d) : cw_d;
		hi_v     = v_shift_q[SHIFT_W-1] ? cw_d - CW_W'(mag_v_d) : cw_d;
	end

	always_ff @(posedge clk) begin
		lw_q    <= lw_d;
		cw_q    <= cw_d;
		mag_u_q <= mag_u_d;
		mag_v_q <= mag_v_d;
		neg_u_q <= u_shift_q[SHIFT_W-1] && (mag_u_d != '0);
		neg_v_q <= v_shift_q[SHIFT_W-1] && (mag_v_d != '0);
		pos_u_q <= !u_shift_q[SHIFT_W-1] && (mag_u_d != '0);
		pos_v_q <= !v_shift_q[SHIFT_W-1] && (mag_v_d != '0);
		lo_c_q  <= (lo_u > lo_v) ? lo_u : lo_v;
		hi_c_q  <= (hi_u < hi_v) ? hi_u : hi_v;
	end

	assign in_ch.ready = !full && !cfg_hold_q;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign act         = in_fire && (in_ch.plane != PLANE_NONE);
	assign is_luma     = (in_ch.plane == PLANE_Y);
	assign shift_en    = act && !is_luma;

	genvar k;
	generate
		for (k = 0; k < MAX_SHIFT; k++) begin : g_cell
			if (k == 0) begin : g_head
				chs_cell u_cell (.clk(clk), .en(shift_en), .d(in_ch.sample), .q(cell_q[k]));
			end else begin : g_body
				chs_cell u_cell (.clk(clk), .en(shift_en), .d(cell_q[k-1]), .q(cell_q[k]));
			end
		end
	endgenerate

	always_comb begin
		rw      = is_luma ? lw_q : LW_W'(cw_q);
		newrow  = (in_ch.plane != cur_plane_q) || (LW_W'(col_q) >= rw);
		c       = newrow ? '0 : col_q;
		c_inc   = LW_W'(c) + LW_W'(1);
		mag     = (in_ch.plane == PLANE_U) ? mag_u_q : mag_v_q;
		neg     = (in_ch.plane == PLANE_U) ? neg_u_q : neg_v_q;
		pos     = (in_ch.plane == PLANE_U) ? pos_u_q : pos_v_q;
		tap_idx = TAP_W'(mag - MAG_W'(1));
		tap     = cell_q[tap_idx];
		oc      = neg ? c - COL_W'(mag) : c;
		blank_c = (oc < COL_W'(lo_c_q)) || (oc >= COL_W'(hi_c_q));
		blank_l = (c < COL_W'({lo_c_q, 1'b0})) || (LW_W'(c) >= {hi_c_q, 1'b0});

		rec.plane = in_ch.plane;
		rec.prim  = 1'b1;
		rec.flush = '0;
		rec.value = in_ch.sample;
		if (is_luma) begin
			if (blank_l) begin
				rec.value = BLANK_LUMA;
			end
		end else if (pos) begin
			rec.value = (c >= COL_W'(mag)) ? tap : BLANK_CHROMA;
			if (blank_c) begin
				rec.value = BLANK_CHROMA;
			end
		end else begin
			if (neg) begin
				// Drop the first samples of the row; pad blanks after its last one.
				rec.prim = (c >= COL_W'(mag));
				if (LW_W'(c) == LW_W'(cw_q) - LW_W'(1)) begin
					rec.flush = mag;
				end
			end
			if (blank_c) begin
				rec.value = BLANK_CHROMA;
			end
		end
		push = act && (rec.prim || (rec.flush != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			cur_plane_q <= PLANE_Y;
		end else if (act) begin
			cur_plane_q <= in_ch.plane;
			col_q       <= (c_inc >= rw) ? '0 : c_inc[COL_W-1:0];
		end
	end

	chs_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.rec    (rec),
		.full   (full),
		.out_ch (out_ch)
	);
endmodule
